// File: hw/rtl/binary_min_heap_defines.svh
// ----------------------------------------------------------------------------
// Binary min-heap assertion macros
// Shared checker macros for the heap controller and datapath.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_DEFINES_SVH
`define BINARY_MIN_HEAP_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define BMH_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked implication check
`define BMH_CHECK_IMP(lbl, ante, cons, msg) \
    `BMH_CHECK(lbl, (ante) |-> (cons), msg)
`else
`define BMH_CHECK(lbl, prop, msg)
`define BMH_CHECK_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// Binary min-heap package
// Sizes, codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_cnt;

    // Operation codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Datapath commands from the controller
    typedef struct packed {
        logic load_push;    // key <= value, pos <= size, size++
        logic dec_size;     // size--, read last entry
        logic load_key;     // key <= read data, pos <= root
        logic rd_parent;    // read parent of pos
        logic rd_children;  // read both children of pos
        logic wr_key;       // store key at pos
        logic up_move;      // move parent down to pos, pos <= parent
        logic dn_move;      // move best child up to pos, pos <= child
    } t_dp_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic pos_zero;
        logic up_less;
        logic has_left;
        logic dn_swap;
    } t_dp_stat;

endpackage

// File: hw/rtl/bmh_datapath.sv
// ----------------------------------------------------------------------------
// Binary min-heap datapath
// Heap memory, sifting key and position, entry count and root copy.
// ----------------------------------------------------------------------------
`include "binary_min_heap_defines.svh"

module bmh_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmh_pkg::t_dp_cmd  i_cmd,
    input  bmh_pkg::t_key     i_value,
    output bmh_pkg::t_dp_stat o_stat,
    output bmh_pkg::t_key     o_min_value,
    output logic              o_heap_empty,
    output bmh_pkg::t_cnt     o_entry_count
);
    import bmh_pkg::*;

    t_key r_heap_mem [CAPACITY];

    t_cnt  r_size, n_size;
    t_key  r_key, n_key;
    t_addr r_pos, n_pos;
    t_key  r_root;
    t_key  r_rd_a, r_rd_b;

    t_addr               pos_m1;
    t_addr               parent;
    t_cnt                size_m1;
    logic [CHILD_W-1:0]  left_idx;
    logic [CHILD_W-1:0]  right_idx;
    logic [CHILD_W-1:0]  size_ext;
    logic                right_ok;
    logic                sel_left;
    logic                sel_right;
    t_key                best_val;
    t_addr               rd_addr_a;
    t_addr               rd_addr_b;
    logic                wr_en;
    t_key                wr_data;

    // Index arithmetic
    assign pos_m1    = r_pos - 1'b1;
    assign parent    = pos_m1 >> 1;
    assign size_m1   = r_size - 1'b1;
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign size_ext  = CHILD_W'(r_size);
    assign right_ok  = right_idx < size_ext;

    // Pick the strictly smallest of key, left and right; key wins any tie, left beats right
    always_comb begin
        sel_left  = r_rd_a < r_key;
        best_val  = sel_left ? r_rd_a : r_key;
        sel_right = right_ok && (r_rd_b < best_val);
        if (sel_right) begin
            best_val = r_rd_b;
        end
    end

    // Read addresses
    always_comb begin
        rd_addr_a = left_idx[ADDR_W-1:0];
        if (i_cmd.dec_size) begin
            rd_addr_a = size_m1[ADDR_W-1:0];
        end else if (i_cmd.rd_parent) begin
            rd_addr_a = parent;
        end
        rd_addr_b = right_idx[ADDR_W-1:0];
    end

    // Write port: always at the current position
    assign wr_en   = i_cmd.wr_key || i_cmd.up_move || i_cmd.dn_move;
    always_comb begin
        wr_data = r_key;
        if (i_cmd.up_move) begin
            wr_data = r_rd_a;
        end else if (i_cmd.dn_move) begin
            wr_data = best_val;
        end
    end

    // Memory with registered reads, taken only when requested
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap_mem[r_pos] <= wr_data;
        end
        if (i_cmd.dec_size || i_cmd.rd_parent || i_cmd.rd_children) begin
            r_rd_a <= r_heap_mem[rd_addr_a];
        end
        if (i_cmd.rd_children) begin
            r_rd_b <= r_heap_mem[rd_addr_b];
        end
    end

    // Next key, position and count
    always_comb begin
        n_size = r_size;
        n_key  = r_key;
        n_pos  = r_pos;
        if (i_cmd.load_push) begin
            n_key  = i_value;
            n_pos  = r_size[ADDR_W-1:0];
            n_size = r_size + 1'b1;
        end
        if (i_cmd.dec_size) begin
            n_size = size_m1;
        end
        if (i_cmd.load_key) begin
            n_key = r_rd_a;
            n_pos = '0;
        end
        if (i_cmd.up_move) begin
            n_pos = parent;
        end
        if (i_cmd.dn_move) begin
            n_pos = sel_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        end
    end

    // Count is control state; key and position are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else begin
            r_size <= n_size;
        end
        r_key <= n_key;
        r_pos <= n_pos;
    end

    // Keep a copy of the root entry
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_pos == '0)) begin
            r_root <= wr_data;
        end
    end

    // Status to the controller
    assign o_stat.full     = r_size == t_cnt'(CAPACITY);
    assign o_stat.empty    = r_size == '0;
    assign o_stat.one_left = r_size == t_cnt'(1);
    assign o_stat.pos_zero = r_pos == '0;
    assign o_stat.up_less  = r_key < r_rd_a;
    assign o_stat.has_left = left_idx < size_ext;
    assign o_stat.dn_swap  = sel_left || sel_right;

    // Result fields
    assign o_heap_empty  = r_size == '0;
    assign o_min_value   = (r_size == '0) ? '0 : r_root;
    assign o_entry_count = r_size;

    `BMH_CHECK(a_size_bound, r_size <= t_cnt'(CAPACITY), "entry count above capacity")

endmodule

// File: hw/rtl/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// Binary min-heap controller
// Sequences push and pop sifting over the datapath and issues the result.
// ----------------------------------------------------------------------------
`include "binary_min_heap_defines.svh"

module bmh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_command,
    input  bmh_pkg::t_dp_stat i_stat,
    output bmh_pkg::t_dp_cmd  o_cmd,
    output logic              busy,
    output logic              o_valid,
    output logic [1:0]        o_status
);
    import bmh_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LOAD = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic [1:0] r_status, n_status;
    logic       accept;
    logic [2:0] wr_cmds;

    assign accept = start && !busy;

    // Next state, datapath commands and result issue
    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_PUSH) begin
                        if (i_stat.full) begin
                            n_valid  = 1'b1;
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.load_push = 1'b1;
                            n_status        = ST_OK;
                            n_state         = S_UP_RD;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            n_valid  = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            o_cmd.dec_size = 1'b1;
                            n_status       = ST_OK;
                            if (i_stat.one_left) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_DN_LOAD;
                            end
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.wr_key = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DN_LOAD: begin
                o_cmd.load_key = 1'b1;
                n_state        = S_DN_RD;
            end
            S_DN_RD: begin
                if (!i_stat.has_left) begin
                    o_cmd.wr_key = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_children = 1'b1;
                    n_state           = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_swap) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign wr_cmds  = {o_cmd.wr_key, o_cmd.up_move, o_cmd.dn_move};

    `BMH_CHECK(a_one_write, $onehot0(wr_cmds), "more than one memory write")
    `BMH_CHECK_IMP(a_valid_idle, o_valid, r_state == S_IDLE, "result while sifting")
    `BMH_CHECK(a_full_drop, (accept && (i_command == CMD_PUSH) && i_stat.full) |=> (o_valid && (o_status == ST_FULL)), "full push not flagged")

endmodule

// File: hw/rtl/binary_min_heap.sv
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Push/pop of signed 32-bit keys with a status result for every command.
// ----------------------------------------------------------------------------
//  Channel  | Handshake        | Payload
//  ---------+------------------+------------------------------------------------
//  command  | start / busy     | i_command, i_value
//  result   | o_valid (1 cyc)  | o_min_value, o_heap_empty, o_entry_count, o_status
//
//  A push appends the key at the end and sifts it up; a pop moves the last
//  entry to the root and sifts it down. Each level costs one registered
//  memory read and one compare-and-move.
//  Dropped pushes, ignored pops and pops of the last entry report in the
//  cycle after they are accepted. Reset is synchronous and empties the heap;
//  no clearing pass is needed. The result is shown for one cycle and cannot
//  stall.
module binary_min_heap (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  bmh_pkg::t_key        i_value,
    output logic                 o_valid,
    output bmh_pkg::t_key        o_min_value,
    output logic                 o_heap_empty,
    output bmh_pkg::t_cnt        o_entry_count,
    output logic [1:0]           o_status
);
    import bmh_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    bmh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_status  (o_status)
    );

    // Heap storage and compare
    bmh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_value       (i_value),
        .o_stat        (dp_stat),
        .o_min_value   (o_min_value),
        .o_heap_empty  (o_heap_empty),
        .o_entry_count (o_entry_count)
    );

endmodule

// File: sim/binary_min_heap_test.sv
// ----------------------------------------------------------------------------
// Binary min-heap testbench
// Drives push/pop commands through the start/busy handshake and checks every
// result strobe against a behavioral heap kept in the bench: directed edge
// cases first, then long random traffic with fill and drain bias and
// varying sender gaps.
// ----------------------------------------------------------------------------
module binary_min_heap_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bmh_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // One result strobe as the heap should report it
    typedef struct {
        t_key       min_value;
        logic       heap_empty;
        t_cnt       entry_count;
        logic [1:0] status;
    } t_heap_result;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       start     = 1'b0;
    logic       i_command = CMD_PUSH;
    t_key       i_value   = '0;
    logic       busy;
    logic       o_valid;
    t_key       o_min_value;
    logic       o_heap_empty;
    t_cnt       o_entry_count;
    logic [1:0] o_status;

    // Behavioral heap and the results it predicts
    t_key         model_keys [CAPACITY];
    int           model_size = 0;
    t_heap_result expected_heap_state [$];
    int           mismatch_count = 0;

    binary_min_heap DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_min_value   (o_min_value),
        .o_heap_empty  (o_heap_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Apply one command to the behavioral heap and return the expected result
    function automatic t_heap_result heap_model_apply(logic cmd, t_key key);
        t_heap_result res;
        t_key         tmp;
        int           pos;
        int           parent;
        int           left;
        int           right;
        int           best;
        res.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (model_size >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // append and sift up past strictly larger parents
                pos = model_size;
                model_keys[pos] = key;
                model_size++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!(model_keys[pos] < model_keys[parent]))
                        break;
                    tmp = model_keys[pos];
                    model_keys[pos] = model_keys[parent];
                    model_keys[parent] = tmp;
                    pos = parent;
                end
            end
        end else begin
            if (model_size == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // move last entry to the root and sift down, left wins ties
                model_size--;
                model_keys[0] = model_keys[model_size];
                pos = 0;
                while (pos < model_size) begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    best  = pos;
                    if (left < model_size && model_keys[left] < model_keys[best])
                        best = left;
                    if (right < model_size && model_keys[right] < model_keys[best])
                        best = right;
                    if (best == pos)
                        break;
                    tmp = model_keys[pos];
                    model_keys[pos] = model_keys[best];
                    model_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        res.min_value   = (model_size > 0) ? model_keys[0] : '0;
        res.heap_empty  = (model_size == 0);
        res.entry_count = t_cnt'(model_size);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Check each result strobe against the oldest prediction
    always @(posedge i_clk) begin
        t_heap_result exp_res;
        if (i_rst_n && o_valid) begin
            if (expected_heap_state.size() == 0) begin
                report_mismatch("result strobe with no command outstanding");
            end else begin
                exp_res = expected_heap_state.pop_front();
                if (o_min_value !== exp_res.min_value ||
                    o_heap_empty !== exp_res.heap_empty ||
                    o_entry_count !== exp_res.entry_count ||
                    o_status !== exp_res.status) begin
                    report_mismatch($sformatf(
                        {"exp min=%0d empty=%0b count=%0d status=%0d, ",
                         "got min=%0d empty=%0b count=%0d status=%0d"},
                        exp_res.min_value, exp_res.heap_empty, exp_res.entry_count,
                        exp_res.status, o_min_value, o_heap_empty, o_entry_count,
                        o_status));
                end
            end
        end
    end

    // Present one command and hold it until the block takes it
    task automatic send_command(logic cmd, t_key key);
        t_heap_result pred;
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= key;
        do
            @(posedge i_clk);
        while (busy);
        pred = heap_model_apply(cmd, key);
        expected_heap_state = {expected_heap_state, pred};
    endtask

    // Drop start for a random gap with the given chance
    task automatic sender_gap(int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_heap_state.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_key random_key();
        case ($urandom_range(9))
            5, 6, 7: return t_key'(int'($urandom_range(8)) - 4);
            8: begin
                case ($urandom_range(3))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            9:       return t_key'(32'h8000_0000 + $urandom_range(3));
            default: return t_key'($urandom);
        endcase
    endfunction

    task automatic test_pop_empty();
        send_command(CMD_POP, 32'sh1234_5678);
        send_command(CMD_POP, '1);
    endtask

    task automatic test_key_extremes();
        send_command(CMD_PUSH, 32'sh7fff_ffff);
        send_command(CMD_PUSH, 32'sh8000_0000);
        send_command(CMD_PUSH, '0);
        send_command(CMD_PUSH, '1);
        send_command(CMD_PUSH, 32'sd1);
        repeat (6) send_command(CMD_POP, '0);
    endtask

    // Pushes and pops duplicate keys; pause before draining
    task automatic test_equal_keys();
        send_command(CMD_PUSH, 32'sd7);
        send_command(CMD_PUSH, 32'sd7);
        send_command(CMD_PUSH, 32'sd3);
        send_command(CMD_PUSH, 32'sd7);
        send_command(CMD_PUSH, 32'sd3);
        wait_drained();
        repeat (5) send_command(CMD_POP, '0);
    endtask

    // Random traffic in fill, drain and balanced stretches so the heap
    // regularly runs full and empty
    task automatic test_random_traffic(int n_items, int idle_pct);
        int   push_pct;
        logic cmd;
        for (int i = 0; i < n_items; i++) begin
            case ((i / 96) % 3)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
            sender_gap(idle_pct);
            send_command(cmd, random_key());
        end
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_pop_empty();
        test_key_extremes();
        test_equal_keys();
        wait_drained();
        test_random_traffic(400, 0);
        test_random_traffic(400, 67);
        test_random_traffic(350, 26);

        // let any stray strobe show up before closing
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_heap_state.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
